// ----- design/mcwd_pkg.sv -----
// ----------------------------------------------------------------------------
// mcwd_pkg
// Shared types and constants for the multi-channel software watchdog.
// ----------------------------------------------------------------------------
package mcwd_pkg;

  localparam int DEFAULT_MAX_CHANNELS = 10;

  localparam int TIME_W = 48;
  localparam int MS_W   = 32;

  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_KICK     = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  localparam logic [2:0] ST_REGISTERED     = 3'd0;
  localparam logic [2:0] ST_DEADLINE_SHORT = 3'd1;
  localparam logic [2:0] ST_TIMEOUT_SHORT  = 3'd2;
  localparam logic [2:0] ST_FULL           = 3'd3;
  localparam logic [2:0] ST_KICKED         = 3'd4;
  localparam logic [2:0] ST_BAD_HANDLE     = 3'd5;
  localparam logic [2:0] ST_TICK_OK        = 3'd6;
  localparam logic [2:0] ST_EXPIRED        = 3'd7;

  localparam logic CFG_MIN_INITIAL_DEADLINE = 1'b0;
  localparam logic CFG_MIN_TIMEOUT          = 1'b1;

  // 30 min and 5 min in milliseconds
  localparam logic [MS_W-1:0] RST_MIN_INITIAL_DEADLINE = 32'd1800000;
  localparam logic [MS_W-1:0] RST_MIN_TIMEOUT          = 32'd300000;

  typedef struct packed {
    logic [MS_W-1:0] min_initial_deadline;
    logic [MS_W-1:0] min_timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] handle_out;
    logic [3:0] expired_index;
  } res_t;

endpackage

// ----- design/mcwd_ram.sv -----
// ----------------------------------------------------------------------------
// mcwd_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module mcwd_ram #(
  parameter int DEPTH = 10,
  parameter int WIDTH = 64,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/mcwd_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcwd_ctrl
// Request sequencer: registration checks, kicks, millisecond clock and the
// channel scan over the channel memories.
// ----------------------------------------------------------------------------
module mcwd_ctrl import mcwd_pkg::*; #(
  parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS,
  parameter int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             req_type,
  input  logic [MS_W-1:0]        timeout_ms,
  input  logic [MS_W-1:0]        initial_deadline_ms,
  input  logic                   force_req,
  input  logic [3:0]             handle,
  input  cfg_t                   cfg,
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_t                   res,
  output logic                   par_we,
  output logic [AW-1:0]          par_waddr,
  output logic [2*MS_W-1:0]      par_wdata,
  output logic                   kick_we,
  output logic [AW-1:0]          kick_waddr,
  output logic [TIME_W-1:0]      kick_wdata,
  output logic [AW-1:0]          raddr,
  input  logic [2*MS_W-1:0]      par_rdata,
  input  logic [TIME_W-1:0]      kick_rdata
);

  localparam int CW = $clog2(MAX_CHANNELS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic [CW-1:0]     used_count;
  logic [TIME_W-1:0] now_ms;
  logic              tripped;
  logic [3:0]        tripped_index;
  logic [CW-1:0]     rd_idx;
  logic              ev_valid;
  logic [AW-1:0]     ev_idx;

  logic              acc;
  logic              dl_short;
  logic              tmo_short;
  logic              full;
  logic              reg_ok;
  logic              kick_ok;
  logic              issue;
  logic              hit;
  logic [MS_W-1:0]   ev_timeout;
  logic [MS_W-1:0]   ev_deadline;
  logic [TIME_W:0]   expire_at;
  res_t              latched;

  function automatic res_t make_res(logic [2:0] st, logic [3:0] h, logic [3:0] e);
    res_t r;
    r.status        = st;
    r.handle_out    = h;
    r.expired_index = e;
    return r;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign acc       = in_valid && in_ready;

  assign dl_short  = !force_req && (initial_deadline_ms < cfg.min_initial_deadline);
  assign tmo_short = !force_req && (timeout_ms < cfg.min_timeout);
  assign full      = (used_count >= CW'(MAX_CHANNELS));
  assign reg_ok    = !dl_short && !tmo_short && !full;
  assign kick_ok   = ({1'b0, handle} < 5'(used_count));

  assign par_we     = acc && (req_type == REQ_REGISTER) && reg_ok;
  assign par_waddr  = used_count[AW-1:0];
  assign par_wdata  = {timeout_ms, initial_deadline_ms};
  assign kick_we    = par_we || (acc && (req_type == REQ_KICK) && kick_ok);
  assign kick_waddr = (req_type == REQ_REGISTER) ? used_count[AW-1:0] : handle[AW-1:0];
  assign kick_wdata = now_ms;

  // scan pipeline: read stage issues rd_idx, eval stage checks the entry
  assign raddr       = rd_idx[AW-1:0];
  assign ev_timeout  = par_rdata[2*MS_W-1:MS_W];
  assign ev_deadline = par_rdata[MS_W-1:0];
  assign expire_at   = {1'b0, kick_rdata} + (TIME_W+1)'(ev_timeout);
  assign hit = ev_valid && (ev_timeout != '0)
            && (now_ms >= TIME_W'(ev_deadline))
            && ({1'b0, now_ms} >= expire_at);
  assign issue = (state == S_SCAN) && !hit && (rd_idx < used_count);

  always_comb begin
    latched = '0;
    if (tripped) begin
      latched.status        = ST_EXPIRED;
      latched.expired_index = tripped_index;
    end else begin
      latched.status = ST_TICK_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used_count    <= '0;
      now_ms        <= '0;
      tripped       <= 1'b0;
      tripped_index <= '0;
      rd_idx        <= '0;
      ev_valid      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            case (req_type)
              REQ_REGISTER: begin
                state <= S_DONE;
                if (dl_short) begin
                  res <= make_res(ST_DEADLINE_SHORT, 4'd0, 4'd0);
                end else if (tmo_short) begin
                  res <= make_res(ST_TIMEOUT_SHORT, 4'd0, 4'd0);
                end else if (full) begin
                  res <= make_res(ST_FULL, 4'd0, 4'd0);
                end else begin
                  res        <= make_res(ST_REGISTERED, 4'(used_count), 4'd0);
                  used_count <= used_count + 1'b1;
                end
              end
              REQ_KICK: begin
                state <= S_DONE;
                res   <= make_res(kick_ok ? ST_KICKED : ST_BAD_HANDLE, 4'd0, 4'd0);
              end
              REQ_TICK: begin
                now_ms <= now_ms + 1'b1;
                if (tripped) begin
                  state <= S_DONE;
                  res   <= latched;
                end else begin
                  state    <= S_SCAN;
                  rd_idx   <= '0;
                  ev_valid <= 1'b0;
                end
              end
              default: begin
                state <= S_DONE;
                res   <= latched;
              end
            endcase
          end
        end
        S_SCAN: begin
          ev_valid <= issue;
          ev_idx   <= rd_idx[AW-1:0];
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (hit) begin
            tripped       <= 1'b1;
            tripped_index <= 4'(ev_idx);
            res           <= make_res(ST_EXPIRED, 4'd0, 4'(ev_idx));
            state         <= S_DONE;
          end else if (!ev_valid && !issue) begin
            res   <= make_res(ST_TICK_OK, 4'd0, 4'd0);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/multi_channel_software_watchdog_core.sv -----
// ----------------------------------------------------------------------------
// multi_channel_software_watchdog_core
// Watchdog channel table with registration, kicks and a millisecond scan.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_valid/in_ready channel, one transaction per
//   request; each request yields exactly one result transaction on
//   out_valid/out_ready (status, handle_out, expired_index).
//   Register, kick and unknown requests go from idle straight to the done
//   state on acceptance. A tick scans the registered channels through
//   the channel memories at one channel per cycle and stops at the first
//   expired channel; a tick while tripped skips the scan and returns the
//   latched expired result. One request is worked on at a time, so the
//   next one is taken the cycle after the previous result moves into the
//   output register.
//   The user must write the minimum deadline and timeout registers through
//   cfg_we/cfg_index/cfg_data only while no request is in flight; the block
//   itself does not enforce this.
//   Reset clears the channel count, the millisecond clock and the tripped
//   state and restores the minimum registers; the channel memories are not
//   cleared since only registered entries are ever read.
//   A stalled receiver holds the result in the output register; one more
//   request may be accepted and its result waits inside until room frees.
// ----------------------------------------------------------------------------
module multi_channel_software_watchdog_core import mcwd_pkg::*; #(
  parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [MS_W-1:0]   timeout_ms,
  input  logic [MS_W-1:0]   initial_deadline_ms,
  input  logic              force_req,
  input  logic [3:0]        handle,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [3:0]        handle_out,
  output logic [3:0]        expired_index,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [MS_W-1:0]   cfg_data
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  cfg_t              cfg;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              par_we;
  logic [AW-1:0]     par_waddr;
  logic [2*MS_W-1:0] par_wdata;
  logic              kick_we;
  logic [AW-1:0]     kick_waddr;
  logic [TIME_W-1:0] kick_wdata;
  logic [AW-1:0]     raddr;
  logic [2*MS_W-1:0] par_rdata;
  logic [TIME_W-1:0] kick_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_initial_deadline <= RST_MIN_INITIAL_DEADLINE;
      cfg.min_timeout          <= RST_MIN_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_INITIAL_DEADLINE: cfg.min_initial_deadline <= cfg_data;
        CFG_MIN_TIMEOUT:          cfg.min_timeout          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      status        <= res.status;
      handle_out    <= res.handle_out;
      expired_index <= res.expired_index;
    end
  end

  mcwd_ram #(
    .DEPTH (MAX_CHANNELS),
    .WIDTH (2*MS_W),
    .AW    (AW)
  ) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (raddr),
    .rdata (par_rdata)
  );

  mcwd_ram #(
    .DEPTH (MAX_CHANNELS),
    .WIDTH (TIME_W),
    .AW    (AW)
  ) u_kick_ram (
    .clk   (clk),
    .we    (kick_we),
    .waddr (kick_waddr),
    .wdata (kick_wdata),
    .raddr (raddr),
    .rdata (kick_rdata)
  );

  mcwd_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW)
  ) u_ctrl (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .req_type            (req_type),
    .timeout_ms          (timeout_ms),
    .initial_deadline_ms (initial_deadline_ms),
    .force_req           (force_req),
    .handle              (handle),
    .cfg                 (cfg),
    .res_valid           (res_valid),
    .res_ready           (res_ready),
    .res                 (res),
    .par_we              (par_we),
    .par_waddr           (par_waddr),
    .par_wdata           (par_wdata),
    .kick_we             (kick_we),
    .kick_waddr          (kick_waddr),
    .kick_wdata          (kick_wdata),
    .raddr               (raddr),
    .par_rdata           (par_rdata),
    .kick_rdata          (kick_rdata)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> out_valid)
    else $error("result not moved into output register");

  a_handle_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_REGISTERED) |-> (32'(handle_out) < MAX_CHANNELS))
    else $error("handle beyond channel table");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_EXPIRED) |-> (expired_index == '0))
    else $error("expired index set on non-expired result");
`endif

endmodule

// ----- tb/multi_channel_software_watchdog_core_tb.sv -----
// ----------------------------------------------------------------------------
// multi_channel_software_watchdog_core_tb
// Self-checking bench for the watchdog channel table. A predictor tracks
// channels, the millisecond clock and the tripped latch, and every result
// transaction is checked against it. Covers the minimum checks at several
// settings, kicks, scans with skipped channels, a full table, heavy output
// backpressure and the sticky expired state.
// ----------------------------------------------------------------------------
module multi_channel_software_watchdog_core_tb;
  import mcwd_pkg::*;

  localparam int NUM_CHANNELS = DEFAULT_MAX_CHANNELS;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 400;
  localparam int TIE_TIMEOUT = 30;
  localparam int HOLDOFF_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = REQ_TICK;
  logic [MS_W-1:0] timeout_ms = '0;
  logic [MS_W-1:0] initial_deadline_ms = '0;
  logic force_req = 1'b0;
  logic [3:0] handle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [3:0] handle_out;
  logic [3:0] expired_index;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_MIN_INITIAL_DEADLINE;
  logic [MS_W-1:0] cfg_data = '0;

  // predicted watchdog state
  logic [MS_W-1:0] floor_deadline = RST_MIN_INITIAL_DEADLINE;
  logic [MS_W-1:0] floor_timeout = RST_MIN_TIMEOUT;
  logic [MS_W-1:0] ch_timeout [NUM_CHANNELS];
  logic [MS_W-1:0] ch_deadline [NUM_CHANNELS];
  logic [TIME_W-1:0] ch_kicked_at [NUM_CHANNELS];
  int unsigned chans_used = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  logic has_tripped = 1'b0;
  logic [3:0] trip_chan = '0;

  res_t answer_q [$];
  int errors = 0;
  int quiet_cycles = 0;
  int hold_req = 0;
  int burst_left = 0;
  bit idling_on = 1'b1;

  multi_channel_software_watchdog_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .timeout_ms(timeout_ms),
    .initial_deadline_ms(initial_deadline_ms),
    .force_req(force_req),
    .handle(handle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .handle_out(handle_out),
    .expired_index(expired_index),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic res_t predict_answer(logic [1:0] req, logic [MS_W-1:0] tmo,
                                          logic [MS_W-1:0] dl, logic frc, logic [3:0] h);
    res_t ans;
    logic [TIME_W:0] due;
    ans = '0;
    case (req)
      REQ_REGISTER: begin
        if (!frc && dl < floor_deadline) begin
          ans.status = ST_DEADLINE_SHORT;
        end else if (!frc && tmo < floor_timeout) begin
          ans.status = ST_TIMEOUT_SHORT;
        end else if (chans_used >= NUM_CHANNELS) begin
          ans.status = ST_FULL;
        end else begin
          ch_timeout[chans_used] = tmo;
          ch_deadline[chans_used] = dl;
          ch_kicked_at[chans_used] = clock_ms;
          ans.status = ST_REGISTERED;
          ans.handle_out = 4'(chans_used);
          chans_used++;
        end
      end
      REQ_KICK: begin
        if (h < chans_used) begin
          ch_kicked_at[h] = clock_ms;
          ans.status = ST_KICKED;
        end else begin
          ans.status = ST_BAD_HANDLE;
        end
      end
      default: begin
        if (req == REQ_TICK) begin
          clock_ms = clock_ms + 1'b1;
          for (int i = 0; i < chans_used; i++) begin
            due = {1'b0, ch_kicked_at[i]} + ch_timeout[i];
            if (!has_tripped && ch_timeout[i] != 0 && clock_ms >= ch_deadline[i] &&
                {1'b0, clock_ms} >= due) begin
              has_tripped = 1'b1;
              trip_chan = 4'(i);
            end
          end
        end
        if (has_tripped) begin
          ans.status = ST_EXPIRED;
          ans.expired_index = trip_chan;
        end else begin
          ans.status = ST_TICK_OK;
        end
      end
    endcase
    return ans;
  endfunction

  // enabled channel that would expire first if left alone
  function automatic logic [3:0] most_urgent_channel();
    logic [TIME_W:0] soonest;
    logic [TIME_W:0] due;
    logic [3:0] pick;
    soonest = '1;
    pick = '0;
    for (int i = 0; i < chans_used; i++) begin
      due = {1'b0, ch_kicked_at[i]} + ch_timeout[i];
      if (due < ch_deadline[i]) due = ch_deadline[i];
      if (ch_timeout[i] != 0 && due < soonest) begin
        soonest = due;
        pick = 4'(i);
      end
    end
    return pick;
  endfunction

  task automatic send_item(logic [1:0] req, logic [MS_W-1:0] tmo, logic [MS_W-1:0] dl,
                           logic frc, logic [3:0] h);
    int gap;
    gap = 0;
    if (idling_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    timeout_ms <= tmo;
    initial_deadline_ms <= dl;
    force_req <= frc;
    handle <= h;
    do @(posedge clk); while (!in_ready);
    answer_q.push_back(predict_answer(req, tmo, dl, frc, h));
  endtask

  task automatic wait_for_answers();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_floor(logic idx, logic [MS_W-1:0] val);
    wait_for_answers();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_INITIAL_DEADLINE) floor_deadline = val;
    else floor_timeout = val;
  endtask

  task automatic test_reset_floors();
    send_item(REQ_REGISTER, '1, RST_MIN_INITIAL_DEADLINE - 1, 1'b0, 4'd0);
    send_item(REQ_REGISTER, RST_MIN_TIMEOUT - 1, RST_MIN_INITIAL_DEADLINE, 1'b0, 4'd0);
    send_item(REQ_REGISTER, '0, '0, 1'b0, 4'd0);
    // forced, zero timeout: channel 0 stays disabled
    send_item(REQ_REGISTER, '0, '0, 1'b1, 4'd0);
    send_item(REQ_KICK, '1, '1, 1'b1, 4'd15);
    send_item(REQ_KICK, '0, '0, 1'b0, 4'd1);
    send_item(REQ_KICK, '0, '0, 1'b0, 4'd0);
    send_item(REQ_UNKNOWN, '1, '1, 1'b1, 4'd15);
    send_item(REQ_TICK, '0, '0, 1'b0, 4'd0);
  endtask

  task automatic test_floor_extremes();
    write_floor(CFG_MIN_INITIAL_DEADLINE, '1);
    write_floor(CFG_MIN_TIMEOUT, '1);
    send_item(REQ_REGISTER, '1, 32'hFFFF_FFFE, 1'b0, 4'd0);
    send_item(REQ_REGISTER, 32'hFFFF_FFFE, '1, 1'b0, 4'd0);
    send_item(REQ_REGISTER, '1, '1, 1'b0, 4'd0);
    write_floor(CFG_MIN_INITIAL_DEADLINE, '0);
    write_floor(CFG_MIN_TIMEOUT, '0);
    // expired by kick time but held back by its deadline
    send_item(REQ_REGISTER, 32'd1, '1, 1'b1, 4'd0);
    // pair with equal timeout and kick time, lower index must win
    send_item(REQ_REGISTER, TIE_TIMEOUT, '0, 1'b0, 4'd0);
    send_item(REQ_REGISTER, TIE_TIMEOUT, '0, 1'b0, 4'd0);
    send_item(REQ_TICK, '1, '1, 1'b1, 4'd15);
    send_item(REQ_TICK, '0, '0, 1'b0, 4'd0);
  endtask

  task automatic test_random_traffic();
    int pick;
    logic [3:0] h;
    logic [MS_W-1:0] tmo;
    logic [MS_W-1:0] dl;
    write_floor(CFG_MIN_INITIAL_DEADLINE, 32'd20);
    write_floor(CFG_MIN_TIMEOUT, 32'd40);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) idling_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_item(REQ_TICK, $urandom, $urandom, 1'($urandom), 4'($urandom));
      end else if (pick < 70) begin
        h = ($urandom_range(0, 4) != 0) ? most_urgent_channel() : 4'($urandom);
        send_item(REQ_KICK, $urandom, $urandom, 1'($urandom), h);
      end else if (pick < 85) begin
        if ($urandom_range(0, 9) < 7) begin
          tmo = $urandom_range(150, 35);
          dl = clock_ms[MS_W-1:0] + $urandom_range(100, 0);
        end else begin
          tmo = $urandom;
          dl = $urandom;
        end
        send_item(REQ_REGISTER, tmo, dl, 1'($urandom), 4'($urandom));
      end else if (pick < 93) begin
        send_item(REQ_UNKNOWN, $urandom, $urandom, 1'($urandom), 4'($urandom));
      end else begin
        h = 4'($urandom_range(15, chans_used));
        send_item(REQ_KICK, $urandom, $urandom, 1'($urandom), h);
      end
    end
    idling_on = 1'b1;
  endtask

  task automatic test_backpressure();
    idling_on = 1'b0;
    hold_req = HOLDOFF_CYCLES;
    for (int n = 0; n < 16; n++) begin
      if (n % 2 == 0) send_item(REQ_TICK, $urandom, $urandom, 1'($urandom), 4'($urandom));
      else send_item(REQ_KICK, '0, '0, 1'b0, most_urgent_channel());
    end
    idling_on = 1'b1;
    wait_for_answers();
  endtask

  task automatic test_fill_table();
    while (chans_used < NUM_CHANNELS) send_item(REQ_REGISTER, '1, '0, 1'b1, 4'd0);
    send_item(REQ_REGISTER, '1, '1, 1'b1, 4'd0);
    send_item(REQ_REGISTER, '1, '1, 1'b0, 4'd0);
  endtask

  task automatic test_trip_and_latch();
    int n;
    for (int i = 0; i < chans_used; i++) send_item(REQ_KICK, '0, '0, 1'b0, 4'(i));
    n = 0;
    while (!has_tripped && n < 200) begin
      send_item(REQ_TICK, $urandom, $urandom, 1'($urandom), 4'($urandom));
      n++;
    end
    repeat (4) send_item(REQ_TICK, '0, '0, 1'b0, 4'd0);
    send_item(REQ_REGISTER, '1, '1, 1'b1, 4'd0);
    send_item(REQ_KICK, '0, '0, 1'b0, 4'd3);
    send_item(REQ_KICK, '0, '0, 1'b0, 4'd15);
    send_item(REQ_UNKNOWN, '0, '0, 1'b0, 4'd0);
    send_item(REQ_TICK, '1, '1, 1'b1, 4'd15);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_floors();
    test_floor_extremes();
    test_random_traffic();
    test_backpressure();
    test_fill_table();
    test_trip_and_latch();
    wait_for_answers();
    repeat (30) @(posedge clk);
    if (errors == 0) $display("multi_channel_software_watchdog_core: match");
    else $display("multi_channel_software_watchdog_core: mismatch");
    $finish;
  end

  // output side: long hold-off on request, otherwise a changing stall rate
  initial begin
    int stall_pct;
    int left;
    int n;
    stall_pct = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        if (left == 0) begin
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 60;
            default: stall_pct = 90;
          endcase
          left = $urandom_range(20, 80);
        end
        left--;
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("result transaction with nothing expected: status %0d", status);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (handle_out !== want.handle_out) begin
          $error("handle_out: expected %0d, got %0d", want.handle_out, handle_out);
          errors++;
        end
        if (expired_index !== want.expired_index) begin
          $error("expired_index: expected %0d, got %0d", want.expired_index, expired_index);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("multi_channel_software_watchdog_core: mismatch");
      $finish;
    end
  end

endmodule
